// ----- hw/rtl/text_line_normalizer_unit_assert.svh -----
// Assertion macros for the text line normalizer.
// Needs a clock and an active-low reset named at each use.
`ifndef TEXT_LINE_NORMALIZER_UNIT_ASSERT_SVH
`define TEXT_LINE_NORMALIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TLN_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication.
`define TLN_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/tln_pkg.sv -----
// Shared types and constants for the text line normalizer.
// No dependencies.
package tln_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] MAX_LINE_RESET = 16'd255;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } result_t;

    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     slot;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/text_line_normalizer_unit.sv -----
// Text line normalizer: one byte per cycle in, normalized line words out.
// Path: the words of an accepted byte are written to the command queue, then loaded into the output register.
// Throughput: one byte per cycle; a byte yielding k words holds the back end until all k are sent,
// and the input stalls only when the command queue is full.
// Reset: asynchronous, active low; clears line state, queue and output, limit to 255.
// Depends on tln_pkg, tln_front, tln_queue, tln_back and the assertion macro header.
module text_line_normalizer_unit #(
    parameter int QUEUE_DEPTH = tln_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last_of_line,
    output logic        stream_done,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data
);
    import tln_pkg::*;

    `include "text_line_normalizer_unit_assert.svh"

    logic      accept;
    logic      push;
    logic      pop;
    cmd_t      cmd;
    cmd_t      head;
    q_status_t status;

    assign in_ready = !status.full;
    assign accept   = in_valid && in_ready;

    tln_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_char        (in_char),
        .end_of_input   (end_of_input),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push),
        .cmd            (cmd)
    );

    tln_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (cmd),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    tln_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .last_of_line (last_of_line),
        .stream_done  (stream_done)
    );

    `TLN_ASSERT_IMPLY(a_done_word_clean, clk, rst_n, out_valid && stream_done, !last_of_line && out_char == 8'd0)
    `TLN_ASSERT_NEXT(a_eoi_queued, clk, rst_n, accept && end_of_input, !status.empty)
    `TLN_ASSERT_NEXT(a_back_fills, clk, rst_n, !status.empty && !out_valid, out_valid)

endmodule

// ----- hw/rtl/tln_front.sv -----
// Front end: accepts and classifies bytes, keeps line state, builds word commands.
// Depends on tln_pkg.
module tln_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_char,
    input  logic                 end_of_input,
    input  logic                 cfg_write_en,
    input  logic [15:0]          cfg_write_data,
    output logic                 push,
    output tln_pkg::cmd_t        cmd
);
    import tln_pkg::*;

    logic [15:0] max_line_reg;
    logic [7:0]  held_char_reg, held_char_next;
    logic        held_valid_reg, held_valid_next;
    logic        space_pending_reg, space_pending_next;
    logic        prev_space_reg, prev_space_next;
    logic        in_quotes_reg, in_quotes_next;
    logic        skipping_reg, skipping_next;
    logic [15:0] line_len_reg, line_len_next;

    logic [15:0] lim;
    logic [15:0] len_inc;
    logic        is_white;
    logic        finish;
    logic [1:0]  n;

    always_comb
    begin
        lim      = (max_line_reg == 16'd0) ? 16'd1 : max_line_reg;
        len_inc  = line_len_reg + 16'd1;
        is_white = (in_char == CHAR_SPACE) || (in_char inside {[8'h09:8'h0D]});
        held_char_next     = held_char_reg;
        held_valid_next    = held_valid_reg;
        space_pending_next = space_pending_reg;
        prev_space_next    = prev_space_reg;
        in_quotes_next     = in_quotes_reg;
        skipping_next      = skipping_reg;
        line_len_next      = line_len_reg;
        cmd    = '0;
        n      = 2'd0;
        finish = 1'b0;
        if (accept)
        begin
            if (end_of_input)
            begin
                if (held_valid_reg)
                begin
                    cmd.slot[n] = '{ch: held_char_reg, last: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                end
                cmd.slot[n] = '{ch: 8'd0, last: 1'b0, done: 1'b1};
                n = n + 2'd1;
                held_char_next     = '0;
                held_valid_next    = 1'b0;
                space_pending_next = 1'b0;
                prev_space_next    = 1'b1;
                in_quotes_next     = 1'b0;
                skipping_next      = 1'b0;
                line_len_next      = '0;
            end
            else if (skipping_reg)
            begin
                if (in_char == CHAR_NL)
                begin
                    skipping_next = 1'b0;
                end
            end
            else if (in_char == CHAR_NL)
            begin
                finish = 1'b1;
            end
            else if (in_char == CHAR_HASH && !in_quotes_reg)
            begin
                finish        = 1'b1;
                skipping_next = 1'b1;
            end
            else if (is_white && !in_quotes_reg)
            begin
                if (!prev_space_reg)
                begin
                    prev_space_next    = 1'b1;
                    space_pending_next = 1'b1;
                    line_len_next      = len_inc;
                    finish             = (len_inc >= lim);
                end
            end
            else
            begin
                prev_space_next = 1'b0;
                if (in_char == CHAR_QUOTE)
                begin
                    in_quotes_next = !in_quotes_reg;
                end
                if (held_valid_reg)
                begin
                    cmd.slot[n] = '{ch: held_char_reg, last: 1'b0, done: 1'b0};
                    n = n + 2'd1;
                end
                if (space_pending_reg)
                begin
                    cmd.slot[n] = '{ch: CHAR_SPACE, last: 1'b0, done: 1'b0};
                    n = n + 2'd1;
                end
                space_pending_next = 1'b0;
                held_char_next     = in_char;
                held_valid_next    = 1'b1;
                line_len_next      = len_inc;
                if (len_inc >= lim)
                begin
                    cmd.slot[n] = '{ch: in_char, last: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                    held_char_next     = '0;
                    held_valid_next    = 1'b0;
                    prev_space_next    = 1'b1;
                    in_quotes_next     = 1'b0;
                    line_len_next      = '0;
                end
            end
            if (finish)
            begin
                if (held_valid_reg)
                begin
                    cmd.slot[n] = '{ch: held_char_reg, last: 1'b1, done: 1'b0};
                    n = n + 2'd1;
                end
                held_char_next     = '0;
                held_valid_next    = 1'b0;
                space_pending_next = 1'b0;
                prev_space_next    = 1'b1;
                in_quotes_next     = 1'b0;
                line_len_next      = '0;
            end
        end
        cmd.count = n;
        push      = (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg      <= MAX_LINE_RESET;
            held_char_reg     <= '0;
            held_valid_reg    <= 1'b0;
            space_pending_reg <= 1'b0;
            prev_space_reg    <= 1'b1;
            in_quotes_reg     <= 1'b0;
            skipping_reg      <= 1'b0;
            line_len_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_line_reg <= cfg_write_data;
            end
            held_char_reg     <= held_char_next;
            held_valid_reg    <= held_valid_next;
            space_pending_reg <= space_pending_next;
            prev_space_reg    <= prev_space_next;
            in_quotes_reg     <= in_quotes_next;
            skipping_reg      <= skipping_next;
            line_len_reg      <= line_len_next;
        end
    end

endmodule

// ----- hw/rtl/tln_queue.sv -----
// Short command queue between front and back ends.
// Depends on tln_pkg.
module tln_queue #(
    parameter int DEPTH = tln_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tln_pkg::cmd_t        wr_cmd,
    input  logic                 pop,
    output tln_pkg::cmd_t        head,
    output tln_pkg::q_status_t   status
);
    import tln_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        status.full  = (count_reg == FULL_CNT);
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        head         = mem_reg[rd_ptr_reg];
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/tln_back.sv -----
// Back end: walks the words of each queued command into the output register.
// Depends on tln_pkg.
module tln_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tln_pkg::cmd_t        head,
    input  tln_pkg::q_status_t   status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 last_of_line,
    output logic                 stream_done
);
    import tln_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    result_t    data_reg, data_next;
    logic       load;
    logic       emit;

    always_comb
    begin
        load       = !valid_reg || out_ready;
        emit       = load && !status.empty;
        pop        = emit && (idx_reg == head.count - 2'd1);
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (emit)
        begin
            data_next  = head.slot[idx_reg];
            valid_next = 1'b1;
            idx_next   = pop ? 2'd0 : idx_reg + 2'd1;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid    = valid_reg;
    assign out_char     = data_reg.ch;
    assign last_of_line = data_reg.last;
    assign stream_done  = data_reg.done;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for text_line_normalizer_unit: byte words in, line words out.
// Predicts every output word from its own line model and compares in order.
// Depends on tln_pkg and the text_line_normalizer_unit RTL.
module tb_top;
    import tln_pkg::*;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam int         CYCLE_CAP  = 300000;
    localparam int         LONG_HOLD  = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_char = 8'h00;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [7:0]  out_char;
    logic        last_of_line;
    logic        stream_done;
    logic        cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = 16'h0000;

    result_t     expected_words[$];
    result_t     head_word;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    bit          hold_off_req = 1'b0;
    int          sink_wait = 0;

    logic [15:0] line_limit = MAX_LINE_RESET;
    logic [7:0]  held_byte = 8'h00;
    bit          held_live = 1'b0;
    bit          gap_owed = 1'b0;
    bit          after_gap = 1'b1;
    bit          in_string = 1'b0;
    bit          in_comment = 1'b0;
    logic [15:0] line_fill = 16'h0000;

    text_line_normalizer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_char        (in_char),
        .end_of_input   (end_of_input),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .last_of_line   (last_of_line),
        .stream_done    (stream_done),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void push_word(input logic [7:0] c, input bit last, input bit done);
        result_t w;
        w.ch   = c;
        w.last = last;
        w.done = done;
        expected_words.push_back(w);
    endfunction

    function automatic void close_line();
        if (held_live)
            push_word(held_byte, 1'b1, 1'b0);
        held_live = 1'b0;
        held_byte = 8'h00;
        gap_owed  = 1'b0;
        after_gap = 1'b1;
        in_string = 1'b0;
        line_fill = 16'h0000;
    endfunction

    function automatic void split_if_full();
        logic [15:0] lim;
        lim = (line_limit == 16'h0000) ? 16'h0001 : line_limit;
        if (line_fill >= lim)
            close_line();
    endfunction

    function automatic void predict_lines(input logic [7:0] c, input bit eoi);
        if (eoi)
        begin
            close_line();
            push_word(8'h00, 1'b0, 1'b1);
            in_comment = 1'b0;
        end
        else if (in_comment)
        begin
            if (c == CHAR_NL)
                in_comment = 1'b0;
        end
        else if (c == CHAR_NL)
            close_line();
        else if (c == CHAR_HASH && !in_string)
        begin
            close_line();
            in_comment = 1'b1;
        end
        else if (is_blank(c) && !in_string)
        begin
            if (!after_gap)
            begin
                after_gap = 1'b1;
                gap_owed  = 1'b1;
                line_fill = line_fill + 16'd1;
                split_if_full();
            end
        end
        else
        begin
            after_gap = 1'b0;
            if (c == CHAR_QUOTE)
                in_string = !in_string;
            if (held_live)
                push_word(held_byte, 1'b0, 1'b0);
            if (gap_owed)
            begin
                push_word(CHAR_SPACE, 1'b0, 1'b0);
                gap_owed = 1'b0;
            end
            held_byte = c;
            held_live = 1'b1;
            line_fill = line_fill + 16'd1;
            split_if_full();
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with none expected", out_char, 0);
            else
            begin
                head_word = expected_words.pop_front();
                if (out_char !== head_word.ch)
                    report_mismatch("out_char", out_char, head_word.ch);
                if (last_of_line !== head_word.last)
                    report_mismatch("last_of_line", last_of_line, head_word.last);
                if (stream_done !== head_word.done)
                    report_mismatch("stream_done", stream_done, head_word.done);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            sink_wait <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            out_ready <= 1'b0;
        end
        else if (sink_gaps && $urandom_range(0, 6) == 0)
        begin
            sink_wait <= $urandom_range(0, 13);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_word(input logic [7:0] c, input bit eoi);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_char      <= c;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lines(c, eoi);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_word(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        line_limit = v;
    endtask

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'(8'h61 + $urandom_range(0, 25));
        else if (r < 60)
            return CHAR_SPACE;
        else if (r < 65)
            return 8'($urandom_range(CHAR_TAB, CHAR_CR));
        else if (r < 73)
            return CHAR_NL;
        else if (r < 78)
            return CHAR_HASH;
        else if (r < 84)
            return CHAR_QUOTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return MAX_LINE_RESET;
            2: return 16'($urandom_range(1, 65535));
            3: return 16'h0001;
            default: return 16'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic send_random_item();
        if ($urandom_range(0, 39) == 0)
            send_end();
        else
            send_word(text_byte(), 1'b0);
    endtask

    task automatic test_directed();
        send_word(CHAR_SPACE, 1'b0);
        send_text("a");
        send_word(CHAR_TAB, 1'b0);
        send_word(8'h0B, 1'b0);
        send_text("\"x  #\n");
        send_text("#q\n");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(8'h0C, 1'b0);
        send_word(CHAR_NL, 1'b0);
        send_text("z");
        send_end();
        send_end();
    endtask

    task automatic test_limits();
        set_limit(16'h0000);
        send_text("ab c");
        set_limit(16'd2);
        send_text("a bc d\n");
        set_limit(16'hFFFF);
        send_text("abcd");
        set_limit(16'd2);
        send_text("e f\n");
        set_limit(16'd1);
        send_text(" x y");
        send_end();
    endtask

    task automatic test_random_text();
        repeat (6)
        begin
            set_limit(pick_limit());
            repeat (12) send_random_item();
        end
    endtask

    task automatic test_backpressure();
        set_limit(MAX_LINE_RESET);
        hold_off_req = 1'b1;
        repeat (30)
            send_word(($urandom_range(0, 1) != 0) ? CHAR_SPACE
                                                  : 8'(8'h41 + $urandom_range(0, 25)),
                      1'b0);
        send_end();
    endtask

    task automatic test_pause();
        send_text("one two");
        wait_drained();
        send_text(" three\n");
        send_end();
    endtask

    task automatic test_quiet_tail();
        set_limit(pick_limit());
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (30) send_random_item();
        send_end();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_limits();
        test_random_text();
        test_backpressure();
        test_pause();
        test_quiet_tail();
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
